[sv/bf_pkg.sv]
package bf_pkg;

	localparam int unsigned TABLE_WORDS = 1042;
	localparam int unsigned P_WORDS     = 18;
	localparam int unsigned ROUNDS      = 16;
	localparam int unsigned PAIR_DEPTH  = 512;
	localparam int unsigned PAIR_AW     = 9;
	localparam int unsigned P_AW        = 5;
	localparam int unsigned ROUND_W     = 4;

	// first table index of each memory holding a pair of S-boxes
	localparam logic [10:0] PAIR01_BASE = 11'd18;
	localparam logic [10:0] PAIR23_BASE = 11'd530;
	localparam logic [10:0] TABLE_END   = 11'd1042;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_ENCRYPT = 1'b1;

	function automatic logic [31:0] byte_rev(input logic [31:0] v);
		byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [31:0] round_f(input logic [31:0] s0, input logic [31:0] s1,
			input logic [31:0] s2, input logic [31:0] s3);
		round_f = ((s0 + s1) ^ s2) + s3;
	endfunction

endpackage

[sv/bf_sbox_pair.sv]
module bf_sbox_pair (
	input  logic                          clk,
	input  logic                          we,
	input  logic [bf_pkg::PAIR_AW-1:0]    waddr,
	input  logic [31:0]                   wdata,
	input  logic [bf_pkg::PAIR_AW-1:0]    raddr_a,
	input  logic [bf_pkg::PAIR_AW-1:0]    raddr_b,
	output logic [31:0]                   rdata_a,
	output logic [31:0]                   rdata_b
);

	logic [31:0] mem_q [bf_pkg::PAIR_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[sv/blowfish_block_encrypt.sv]
// Blowfish encryption of one 64-bit block against a key table loaded word by word.
// A load (action 0) gives no result; a load address past the table is dropped. An
// encrypt (action 1) keeps busy high through its rounds, one round per cycle, paced
// by the registered read of the two S-box memories (each holds two S-boxes and reads
// both in the same cycle). done pulses for exactly one cycle once the last round is
// through; cipher_block keeps that result until the next encrypt ends, and the
// receiver cannot hold it off. A new item may start in the done cycle, but not while
// busy is high, so each encrypt must finish before the next is taken. Every table
// word an encrypt uses must have been loaded since reset.
module blowfish_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [10:0] word_index,
	input  logic [31:0] word_value,
	input  logic [31:0] block_first_word,
	input  logic [31:0] block_second_word,
	output logic        done,
	output logic [63:0] cipher_block
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                          state_q;
	logic [bf_pkg::ROUND_W-1:0]      round_q;
	logic                            done_q;
	logic [63:0]                     cipher_q;
	logic [31:0]                     x_q;
	logic [31:0]                     y_q;
	logic [31:0]                     p_q [bf_pkg::P_WORDS];

	logic                            take;
	logic                            take_load;
	logic                            take_enc;
	logic [10:0]                     off01;
	logic [10:0]                     off23;
	logic                            we01;
	logic                            we23;
	logic [bf_pkg::P_AW-1:0]         p_next_idx;
	logic [31:0]                     s0;
	logic [31:0]                     s1;
	logic [31:0]                     s2;
	logic [31:0]                     s3;
	logic [31:0]                     f_val;
	logic [31:0]                     next_x;
	logic [31:0]                     start_x;
	logic [31:0]                     look_x;
	logic                            last_round;

	assign busy         = (state_q == ST_RUN);
	assign done         = done_q;
	assign cipher_block = cipher_q;

	assign take      = start && !busy;
	assign take_load = take && (action == bf_pkg::ACT_LOAD);
	assign take_enc  = take && (action == bf_pkg::ACT_ENCRYPT);

	assign off01 = word_index - bf_pkg::PAIR01_BASE;
	assign off23 = word_index - bf_pkg::PAIR23_BASE;
	assign we01  = take_load && (word_index >= bf_pkg::PAIR01_BASE)
		&& (word_index < bf_pkg::PAIR23_BASE);
	assign we23  = take_load && (word_index >= bf_pkg::PAIR23_BASE)
		&& (word_index < bf_pkg::TABLE_END);

	// subkey for the round after this one; at the last round it is P16
	assign p_next_idx = {1'b0, round_q} + bf_pkg::P_AW'(1);
	assign last_round = (round_q == bf_pkg::ROUND_W'(bf_pkg::ROUNDS - 1));

	assign f_val   = bf_pkg::round_f(s0, s1, s2, s3);
	assign next_x  = y_q ^ f_val ^ p_q[p_next_idx];
	assign start_x = bf_pkg::byte_rev(block_first_word) ^ p_q[0];
	assign look_x  = busy ? next_x : start_x;

	bf_sbox_pair u_pair01 (
		.clk     (clk),
		.we      (we01),
		.waddr   (off01[bf_pkg::PAIR_AW-1:0]),
		.wdata   (word_value),
		.raddr_a ({1'b0, look_x[31:24]}),
		.raddr_b ({1'b1, look_x[23:16]}),
		.rdata_a (s0),
		.rdata_b (s1)
	);

	bf_sbox_pair u_pair23 (
		.clk     (clk),
		.we      (we23),
		.waddr   (off23[bf_pkg::PAIR_AW-1:0]),
		.wdata   (word_value),
		.raddr_a ({1'b0, look_x[15:8]}),
		.raddr_b ({1'b1, look_x[7:0]}),
		.rdata_a (s2),
		.rdata_b (s3)
	);

	always_ff @(posedge clk) begin
		if (take_load && (word_index < bf_pkg::PAIR01_BASE)) begin
			p_q[word_index[bf_pkg::P_AW-1:0]] <= word_value;
		end
	end

	// x_q: half whose S-box reads are in flight; y_q: the other half
	always_ff @(posedge clk) begin
		if (take_enc) begin
			x_q <= start_x;
			y_q <= bf_pkg::byte_rev(block_second_word);
		end else if (busy) begin
			x_q <= next_x;
			y_q <= x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			round_q  <= '0;
			done_q   <= 1'b0;
			cipher_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take_enc) begin
						state_q <= ST_RUN;
						round_q <= '0;
					end
				end
				ST_RUN: begin
					round_q <= round_q + bf_pkg::ROUND_W'(1);
					if (last_round) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						cipher_q <= {x_q ^ p_q[bf_pkg::P_WORDS-1], next_x};
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_enc_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		take_enc |=> busy && (round_q == '0))
		else $error("encrypt transfer did not start the rounds");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take_load |=> !busy)
		else $error("load transfer left the block busy");

	a_round_advance: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !last_round |=> busy && (round_q == $past(round_q) + bf_pkg::ROUND_W'(1)))
		else $error("round counter skipped or run ended early");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy && last_round |=> done && !busy)
		else $error("no result after the last round");

	a_done_only_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe without a finished run");

endmodule
